>>> rtl/core/modular_alu_small_modulus_assert.svh
// assertion macros for the modular alu small modulus block
// used by the top level only, no other dependencies
`ifndef MODULAR_ALU_SMALL_MODULUS_ASSERT_SVH
`define MODULAR_ALU_SMALL_MODULUS_ASSERT_SVH

// same-cycle implication
`define MAS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mas_pkg.sv
// types, constants and microcode table for the modular alu small modulus block
// no dependencies; used by mas_div, modular_alu_small_modulus and the testbench
`timescale 1ns / 1ps

package mas_pkg;

  localparam int PC_W = 5;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_STEPS_WIDE = 5'd16;
  localparam logic [CNT_W-1:0] DIV_STEPS_NARROW = 5'd8;

  typedef enum logic [2:0] {
    F_NEG  = 3'd0,
    F_ADD  = 3'd1,
    F_SUB  = 3'd2,
    F_MUL  = 3'd3,
    F_MAC  = 3'd4,
    F_MSUB = 3'd5,
    F_INV  = 3'd6,
    F_DIV  = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_DIV_X,
    U_DIV_Y,
    U_DIV_A,
    U_DIV_P,
    U_DIV_R,
    U_SET_X,
    U_SET_Y,
    U_SET_A,
    U_MUL,
    U_ALU,
    U_EU_INIT,
    U_EU_STEP,
    U_EU_END,
    U_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_REQ,
    C_DIV_BUSY,
    C_X_LT_N,
    C_Y_LT_N,
    C_A_LT_N,
    C_FUNC_ALU,
    C_FUNC_EU,
    C_R1_ZERO,
    C_NOT_INV,
    C_FUNC_INV,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t             op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_ctl_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] quo;
    logic [7:0]  rem;
  } div_res_t;

  // program steps
  localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] S_CHK_X   = 5'd1;
  localparam logic [PC_W-1:0] S_DIV_X   = 5'd2;
  localparam logic [PC_W-1:0] S_WX      = 5'd3;
  localparam logic [PC_W-1:0] S_CHK_Y   = 5'd4;
  localparam logic [PC_W-1:0] S_DIV_Y   = 5'd5;
  localparam logic [PC_W-1:0] S_WY      = 5'd6;
  localparam logic [PC_W-1:0] S_CHK_A   = 5'd7;
  localparam logic [PC_W-1:0] S_DIV_A   = 5'd8;
  localparam logic [PC_W-1:0] S_WA      = 5'd9;
  localparam logic [PC_W-1:0] S_DISP    = 5'd10;
  localparam logic [PC_W-1:0] S_DISP2   = 5'd11;
  localparam logic [PC_W-1:0] S_MUL     = 5'd12;
  localparam logic [PC_W-1:0] S_DIV_P   = 5'd13;
  localparam logic [PC_W-1:0] S_WP      = 5'd14;
  localparam logic [PC_W-1:0] S_ALU     = 5'd15;
  localparam logic [PC_W-1:0] S_EU      = 5'd16;
  localparam logic [PC_W-1:0] S_EU_LOOP = 5'd17;
  localparam logic [PC_W-1:0] S_DIV_R   = 5'd18;
  localparam logic [PC_W-1:0] S_WR      = 5'd19;
  localparam logic [PC_W-1:0] S_EU_UPD  = 5'd20;
  localparam logic [PC_W-1:0] S_EU_END  = 5'd21;
  localparam logic [PC_W-1:0] S_EU_SEL  = 5'd22;
  localparam logic [PC_W-1:0] S_TO_MUL  = 5'd23;
  localparam logic [PC_W-1:0] S_EMIT    = 5'd31;

  // control store; a step whose condition is false falls through to the next one,
  // the emit step is last so that it wraps to idle
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      S_IDLE:    w = '{U_NOP,     C_NO_REQ,   S_IDLE};
      S_CHK_X:   w = '{U_NOP,     C_X_LT_N,   S_CHK_Y};
      S_DIV_X:   w = '{U_DIV_X,   C_NONE,     S_IDLE};
      S_WX:      w = '{U_SET_X,   C_DIV_BUSY, S_WX};
      S_CHK_Y:   w = '{U_NOP,     C_Y_LT_N,   S_CHK_A};
      S_DIV_Y:   w = '{U_DIV_Y,   C_NONE,     S_IDLE};
      S_WY:      w = '{U_SET_Y,   C_DIV_BUSY, S_WY};
      S_CHK_A:   w = '{U_NOP,     C_A_LT_N,   S_DISP};
      S_DIV_A:   w = '{U_DIV_A,   C_NONE,     S_IDLE};
      S_WA:      w = '{U_SET_A,   C_DIV_BUSY, S_WA};
      S_DISP:    w = '{U_NOP,     C_FUNC_ALU, S_ALU};
      S_DISP2:   w = '{U_NOP,     C_FUNC_EU,  S_EU};
      S_MUL:     w = '{U_MUL,     C_NONE,     S_IDLE};
      S_DIV_P:   w = '{U_DIV_P,   C_NONE,     S_IDLE};
      S_WP:      w = '{U_SET_Y,   C_DIV_BUSY, S_WP};
      S_ALU:     w = '{U_ALU,     C_ALWAYS,   S_EMIT};
      S_EU:      w = '{U_EU_INIT, C_NONE,     S_IDLE};
      S_EU_LOOP: w = '{U_NOP,     C_R1_ZERO,  S_EU_END};
      S_DIV_R:   w = '{U_DIV_R,   C_NONE,     S_IDLE};
      S_WR:      w = '{U_NOP,     C_DIV_BUSY, S_WR};
      S_EU_UPD:  w = '{U_EU_STEP, C_ALWAYS,   S_EU_LOOP};
      S_EU_END:  w = '{U_EU_END,  C_NOT_INV,  S_EMIT};
      S_EU_SEL:  w = '{U_NOP,     C_FUNC_INV, S_ALU};
      S_TO_MUL:  w = '{U_NOP,     C_ALWAYS,   S_MUL};
      S_EMIT:    w = '{U_EMIT,    C_OUT_BUSY, S_EMIT};
      default:   w = '{U_NOP,     C_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/modular_alu_small_modulus.sv
// modular alu for a configured modulus up to 255, microcoded sequencer over a small datapath
// depends on mas_pkg, mas_div and modular_alu_small_modulus_assert.svh
//
// requests enter on in_valid/in_stall with func, op_x, op_y and acc_in; each request gives
// one result on out_valid/out_stall carrying result and status (1 = not invertible, result 0).
// the modulus register is written on cfg_valid/cfg_ready with data on modulus; a value of 0
// acts as 1. cfg_ready is high while the sequencer is idle.
// one request is worked at a time: in_stall is low only in the idle step.
// operands at or above the modulus are first reduced on the 8-step divider; neg/add/sub then go
// to the adder, and the multiply forms reduce the product on the wide divider before it. inverse
// runs euclid with one divider pass per iteration (up to about 12 iterations), divide adds
// the multiply path on top. the shared restoring divider sets the cost of every reduction.
// reset clears the sequencer and the output valid and sets the modulus to 1.
// a finished result waits in the output register while out_stall is high; the next request
// is taken as soon as the result is handed to the output register.
`timescale 1ns / 1ps
`include "modular_alu_small_modulus_assert.svh"

module modular_alu_small_modulus (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [7:0] op_x,
  input  logic [7:0] op_y,
  input  logic [7:0] acc_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result,
  output logic       status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] modulus
);

  logic [mas_pkg::PC_W-1:0] pc;
  logic [mas_pkg::PC_W-1:0] pc_next;
  mas_pkg::ucode_t          uc;
  logic                     cond_hit;

  logic [7:0]           n;
  mas_pkg::func_t       fn;
  logic [7:0]           x;
  logic [7:0]           y;
  logic [7:0]           acc;
  logic [15:0]          prod;
  logic [7:0]           r0;
  logic [7:0]           r1;
  logic signed [9:0]    t0;
  logic signed [9:0]    t1;
  logic [7:0]           res;
  logic                 st;

  logic                 in_accept;
  logic                 out_free;
  logic                 out_busy;
  logic                 emit_go;
  logic                 div_wait_step;

  mas_pkg::div_ctl_t    div_ctl;
  mas_pkg::div_res_t    div_res;
  logic [15:0]          div_dividend;
  logic [7:0]           div_divisor;

  logic signed [18:0]   qt;
  logic signed [18:0]   t_diff;
  logic signed [9:0]    t_adj;
  logic [7:0]           inv;

  logic [7:0]           a_sel;
  logic [7:0]           b_sel;
  logic [8:0]           sum;
  logic [8:0]           sum_red;
  logic [8:0]           diff;
  logic [7:0]           alu_out;

  assign in_stall  = (pc != mas_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (pc == mas_pkg::S_IDLE);
  assign out_busy  = out_valid && out_stall;
  assign out_free  = !out_busy;
  assign emit_go   = (uc.op == mas_pkg::U_EMIT) && out_free;
  assign div_wait_step = (pc == mas_pkg::S_WX) || (pc == mas_pkg::S_WY) ||
                         (pc == mas_pkg::S_WA) || (pc == mas_pkg::S_WP) ||
                         (pc == mas_pkg::S_WR);

  // sequencer
  always_comb begin
    uc = mas_pkg::ucode_rom(pc);
    case (uc.cond)
      mas_pkg::C_NONE:     cond_hit = 1'b0;
      mas_pkg::C_ALWAYS:   cond_hit = 1'b1;
      mas_pkg::C_NO_REQ:   cond_hit = !in_accept;
      mas_pkg::C_DIV_BUSY: cond_hit = div_res.busy;
      mas_pkg::C_X_LT_N:   cond_hit = (x < n);
      mas_pkg::C_Y_LT_N:   cond_hit = (y < n);
      mas_pkg::C_A_LT_N:   cond_hit = (acc < n);
      mas_pkg::C_FUNC_ALU: cond_hit = (fn == mas_pkg::F_NEG) || (fn == mas_pkg::F_ADD) ||
                                      (fn == mas_pkg::F_SUB);
      mas_pkg::C_FUNC_EU:  cond_hit = (fn == mas_pkg::F_INV) || (fn == mas_pkg::F_DIV);
      mas_pkg::C_R1_ZERO:  cond_hit = (r1 == 8'd0);
      mas_pkg::C_NOT_INV:  cond_hit = (r0 != 8'd1);
      mas_pkg::C_FUNC_INV: cond_hit = (fn == mas_pkg::F_INV);
      mas_pkg::C_OUT_BUSY: cond_hit = out_busy;
      default:             cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? uc.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mas_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      n <= (modulus == 8'd0) ? 8'd1 : modulus;
    end
  end

  // shared divider
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.wide  = 1'b0;
    div_dividend  = {8'h00, x};
    div_divisor   = n;
    case (uc.op)
      mas_pkg::U_DIV_X: div_ctl.start = 1'b1;
      mas_pkg::U_DIV_Y: begin
        div_ctl.start = 1'b1;
        div_dividend  = {8'h00, y};
      end
      mas_pkg::U_DIV_A: begin
        div_ctl.start = 1'b1;
        div_dividend  = {8'h00, acc};
      end
      mas_pkg::U_DIV_P: begin
        div_ctl.start = 1'b1;
        div_ctl.wide  = 1'b1;
        div_dividend  = prod;
      end
      mas_pkg::U_DIV_R: begin
        div_ctl.start = 1'b1;
        div_dividend  = {8'h00, r0};
        div_divisor   = r1;
      end
      default: div_ctl.start = 1'b0;
    endcase
  end

  mas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  // euclid coefficient update and inverse fix-up
  always_comb begin
    qt     = $signed({11'd0, div_res.quo[7:0]}) * $signed({{9{t1[9]}}, t1});
    t_diff = $signed({{9{t0[9]}}, t0}) - qt;
    t_adj  = t0 + $signed({2'b00, n});
    inv    = t0[9] ? t_adj[7:0] : t0[7:0];
  end

  // add / subtract / negate mod n, other functions pass y through
  always_comb begin
    if ((fn == mas_pkg::F_MAC) || (fn == mas_pkg::F_MSUB)) begin
      a_sel = acc;
    end else if (fn == mas_pkg::F_NEG) begin
      a_sel = 8'd0;
    end else begin
      a_sel = x;
    end
    b_sel   = (fn == mas_pkg::F_NEG) ? x : y;
    sum     = {1'b0, a_sel} + {1'b0, b_sel};
    sum_red = (sum >= {1'b0, n}) ? sum - {1'b0, n} : sum;
    diff    = (a_sel >= b_sel) ? {1'b0, a_sel} - {1'b0, b_sel}
                               : {1'b0, a_sel} + {1'b0, n} - {1'b0, b_sel};
    case (fn)
      mas_pkg::F_ADD,
      mas_pkg::F_MAC:  alu_out = sum_red[7:0];
      mas_pkg::F_NEG,
      mas_pkg::F_SUB,
      mas_pkg::F_MSUB: alu_out = diff[7:0];
      default:         alu_out = y;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fn  <= mas_pkg::func_t'(func);
      x   <= op_x;
      y   <= op_y;
      acc <= acc_in;
    end
    case (uc.op)
      mas_pkg::U_SET_X: x <= div_res.rem;
      mas_pkg::U_SET_Y: y <= div_res.rem;
      mas_pkg::U_SET_A: acc <= div_res.rem;
      mas_pkg::U_MUL:   prod <= x * y;
      mas_pkg::U_ALU: begin
        res <= alu_out;
        st  <= 1'b0;
      end
      mas_pkg::U_EU_INIT: begin
        r0 <= n;
        r1 <= (fn == mas_pkg::F_INV) ? x : y;
        t0 <= 10'sd0;
        t1 <= 10'sd1;
      end
      mas_pkg::U_EU_STEP: begin
        r0 <= r1;
        r1 <= div_res.rem;
        t0 <= t1;
        t1 <= t_diff[9:0];
      end
      mas_pkg::U_EU_END: begin
        if (r0 != 8'd1) begin
          res <= 8'd0;
          st  <= 1'b1;
        end else begin
          y <= inv;
        end
      end
      default: res <= res;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      result <= res;
      status <= st;
    end
  end

  `MAS_ASSERT_IMP(a_div_start_idle, clk, rst, div_ctl.start, !div_res.busy, "divider restarted")
  `MAS_ASSERT_IMP(a_div_busy_wait, clk, rst, div_res.busy, div_wait_step, "busy outside wait")
  `MAS_ASSERT_IMP(a_eu_divisor, clk, rst, uc.op == mas_pkg::U_DIV_R, r1 != 8'd0, "zero divisor")
  `MAS_ASSERT_NXT(a_emit_valid, clk, rst, emit_go, out_valid, "emitted result not presented")
  `MAS_ASSERT_IMP(a_err_zero, clk, rst, out_valid && status, result == 8'd0, "nonzero on error")

endmodule

>>> rtl/core/mas_div.sv
// restoring divider, one quotient bit per cycle, 8 or 16 steps
// depends on mas_pkg for the control and result structs
`timescale 1ns / 1ps

module mas_div (
  input  logic                clk,
  input  logic                rst,
  input  mas_pkg::div_ctl_t   ctl,
  input  logic [15:0]         dividend,
  input  logic [7:0]          divisor,
  output mas_pkg::div_res_t   res
);

  logic [15:0]               dd;
  logic [7:0]                rem;
  logic [7:0]                dsr;
  logic [mas_pkg::CNT_W-1:0] count;
  logic [8:0]                trial;
  logic                      ge;
  logic [8:0]                trial_sub;
  logic [7:0]                rem_next;

  always_comb begin
    trial     = {rem, dd[15]};
    ge        = (trial >= {1'b0, dsr});
    trial_sub = trial - {1'b0, dsr};
    rem_next  = ge ? trial_sub[7:0] : trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.start) begin
      count <= ctl.wide ? mas_pkg::DIV_STEPS_WIDE : mas_pkg::DIV_STEPS_NARROW;
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dd  <= ctl.wide ? dividend : {dividend[7:0], 8'h00};
      rem <= '0;
      dsr <= divisor;
    end else if (count != '0) begin
      dd  <= {dd[14:0], ge};
      rem <= rem_next;
    end
  end

  assign res.busy = (count != '0);
  assign res.quo  = dd;
  assign res.rem  = rem;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// testbench for modular_alu_small_modulus: directed and random requests over many moduli,
// each result checked in order against a modular arithmetic predictor kept in this file
// depends on mas_pkg and the rtl of the block

module testbench;

  typedef enum logic [1:0] {REQ_OP, REQ_CFG, REQ_DRAIN} req_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    req_kind_t      kind;
    mas_pkg::func_t fn;
    logic [7:0]     x;
    logic [7:0]     y;
    logic [7:0]     a;
    logic [7:0]     mod_val;
  } req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       err;
  } mod_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] func = 3'd0;
  logic [7:0] op_x = 8'd0;
  logic [7:0] op_y = 8'd0;
  logic [7:0] acc_in = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] result;
  logic       status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] modulus = 8'd1;

  req_t        pending_reqs[$];
  mod_result_t expected_results[$];

  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic [7:0]  cur_modulus = 8'd1;
  int          accepted_cnt = 0;
  int          cfg_writes = 0;
  int          domain_errs = 0;
  int          fail_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          next_hold_at = 200;
  int          long_holds = 0;
  int          pat_cnt = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [7:0]  phase_mods [0:8] = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd254, 8'd128, 8'd251, 8'd6,
                                    8'd97};

  modular_alu_small_modulus DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .op_x      (op_x),
    .op_y      (op_y),
    .acc_in    (acc_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .modulus   (modulus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic find_inverse(input int a, input int n, output int inv);
    int r0, r1, t0, t1, q, tmp;
    r0 = n;
    r1 = a;
    t0 = 0;
    t1 = 1;
    inv = 0;
    if (n == 1) return 1'b1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - q * t1;
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1) return 1'b0;
    if (t0 < 0) t0 = t0 + n;
    inv = t0 % n;
    return 1'b1;
  endfunction

  function automatic mod_result_t predict_mod_op(input mas_pkg::func_t fn,
                                                 input logic [7:0] xr,
                                                 input logic [7:0] yr, input logic [7:0] ar,
                                                 input logic [7:0] mreg);
    int n, x, y, acc, prod, inv;
    mod_result_t r;
    n = (mreg == 8'd0) ? 1 : int'(mreg);
    x = int'(xr) % n;
    y = int'(yr) % n;
    acc = int'(ar) % n;
    prod = (x * y) % n;
    r.value = 8'd0;
    r.err = 1'b0;
    case (fn)
      mas_pkg::F_NEG:  r.value = 8'((n - x) % n);
      mas_pkg::F_ADD:  r.value = 8'((x + y) % n);
      mas_pkg::F_SUB:  r.value = 8'((x + n - y) % n);
      mas_pkg::F_MUL:  r.value = 8'(prod);
      mas_pkg::F_MAC:  r.value = 8'((acc + prod) % n);
      mas_pkg::F_MSUB: r.value = 8'((acc + n - prod) % n);
      mas_pkg::F_INV: begin
        if (find_inverse(x, n, inv)) r.value = 8'(inv);
        else r.err = 1'b1;
      end
      default: begin
        if (find_inverse(y, n, inv)) r.value = 8'((x * inv) % n);
        else r.err = 1'b1;
      end
    endcase
    return r;
  endfunction

  // mostly reduced operands, some extremes and some unreduced noise
  function automatic logic [7:0] pick_operand(input logic [7:0] mreg);
    int n;
    n = (mreg == 8'd0) ? 1 : int'(mreg);
    case ($urandom_range(0, 19))
      0: return 8'($urandom_range(0, 255));
      1: return 8'(n - 1);
      2: return 8'd0;
      default: return 8'($urandom_range(0, n - 1));
    endcase
  endfunction

  task automatic add_op(input mas_pkg::func_t fn, input logic [7:0] x, input logic [7:0] y,
                        input logic [7:0] a);
    req_t r;
    r = '0;
    r.kind = REQ_OP;
    r.fn = fn;
    r.x = x;
    r.y = y;
    r.a = a;
    pending_reqs.push_back(r);
  endtask

  task automatic add_cfg(input logic [7:0] v);
    req_t r;
    r = '0;
    r.kind = REQ_DRAIN;
    pending_reqs.push_back(r);
    r.kind = REQ_CFG;
    r.mod_val = v;
    pending_reqs.push_back(r);
  endtask

  // request driver
  always @(negedge clk) begin : drive_proc
    logic nv, nc;
    req_t r;
    if (!rst && !(in_valid && !in_taken) && !(cfg_valid && !cfg_taken)) begin
      nv = 1'b0;
      nc = 1'b0;
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs[0];
        case (r.kind)
          REQ_OP: begin
            r = pending_reqs.pop_front();
            func <= r.fn;
            op_x <= r.x;
            op_y <= r.y;
            acc_in <= r.a;
            nv = 1'b1;
            if (burst_left > 1) begin
              burst_left = burst_left - 1;
            end else begin
              burst_left = $urandom_range(1, 40);
              case ($urandom_range(0, 3))
                0, 1: gap_left = 0;
                2: gap_left = $urandom_range(1, 4);
                default: gap_left = $urandom_range(5, 40);
              endcase
            end
          end
          REQ_DRAIN: begin
            if (expected_results.size() == 0) r = pending_reqs.pop_front();
          end
          default: begin
            if (expected_results.size() == 0) begin
              r = pending_reqs.pop_front();
              modulus <= r.mod_val;
              nc = 1'b1;
            end
          end
        endcase
      end
      in_valid <= nv;
      cfg_valid <= nc;
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(negedge clk) begin : hold_proc
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (accepted_cnt >= next_hold_at && long_holds < 2) begin
      hold_left <= 500;
      long_holds <= long_holds + 1;
      next_hold_at <= next_hold_at + 700;
    end
  end

  always @(negedge clk) begin : stall_proc
    logic s;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      pat_cnt = pat_cnt + 1;
      if (pat_cnt % 400 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:   s = 1'b0;
        STALL_RANDOM: s = ($urandom_range(0, 1) == 0);
        STALL_HEAVY:  s = ($urandom_range(0, 7) != 0);
        default:      s = pat_cnt[2] & pat_cnt[0];
      endcase
      out_stall <= s || (hold_left != 0);
    end
  end

  // handshake monitor and result checker
  always @(posedge clk) begin : watch_proc
    mod_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      cfg_taken <= cfg_valid && cfg_ready;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("unexpected result %0d status %0d at %0t", result, status, $time);
        end else begin
          want = expected_results.pop_front();
          if (result !== want.value || status !== want.err) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("mismatch at %0t: expected result %0d status %0d, got %0d status %0d",
                       $time, want.value, want.err, result, status);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cur_modulus = modulus;
        cfg_writes = cfg_writes + 1;
      end
      if (in_valid && !in_stall) begin
        want = predict_mod_op(mas_pkg::func_t'(func), op_x, op_y, acc_in, cur_modulus);
        expected_results.push_back(want);
        accepted_cnt = accepted_cnt + 1;
        if (want.err) domain_errs = domain_errs + 1;
      end
    end
  end

  initial begin : stim_proc
    int k;
    logic [7:0] m;

    // modulus one from reset
    add_op(mas_pkg::F_INV, 8'd0, 8'd0, 8'd0);
    add_op(mas_pkg::F_DIV, 8'd5, 8'd0, 8'd0);
    add_op(mas_pkg::F_NEG, 8'd255, 8'd0, 8'd0);
    // modulus zero acts as one
    add_cfg(8'd0);
    add_op(mas_pkg::F_MAC, 8'd255, 8'd255, 8'd255);
    add_op(mas_pkg::F_DIV, 8'd0, 8'd0, 8'd0);
    add_cfg(8'd255);
    add_op(mas_pkg::F_NEG, 8'd0, 8'd0, 8'd0);
    add_op(mas_pkg::F_NEG, 8'd254, 8'd0, 8'd0);
    add_op(mas_pkg::F_ADD, 8'd254, 8'd254, 8'd0);
    add_op(mas_pkg::F_SUB, 8'd0, 8'd254, 8'd0);
    add_op(mas_pkg::F_MUL, 8'd254, 8'd254, 8'd0);
    add_op(mas_pkg::F_MAC, 8'd254, 8'd254, 8'd254);
    add_op(mas_pkg::F_MSUB, 8'd1, 8'd1, 8'd0);
    add_op(mas_pkg::F_INV, 8'd254, 8'd0, 8'd0);
    add_op(mas_pkg::F_INV, 8'd0, 8'd0, 8'd0);
    add_op(mas_pkg::F_DIV, 8'd7, 8'd254, 8'd0);
    add_op(mas_pkg::F_DIV, 8'd3, 8'd0, 8'd0);
    add_op(mas_pkg::F_ADD, 8'd255, 8'd255, 8'd255);
    // composite modulus, invertible and not invertible cases
    add_cfg(8'd12);
    add_op(mas_pkg::F_INV, 8'd4, 8'd0, 8'd0);
    add_op(mas_pkg::F_INV, 8'd5, 8'd0, 8'd0);
    add_op(mas_pkg::F_DIV, 8'd9, 8'd6, 8'd0);
    add_op(mas_pkg::F_DIV, 8'd200, 8'd7, 8'd0);
    add_op(mas_pkg::F_MSUB, 8'd250, 8'd251, 8'd252);

    for (k = 0; k < 11; k++) begin
      m = (k < 9) ? phase_mods[k] : 8'($urandom_range(3, 253));
      add_cfg(m);
      repeat (150)
        add_op(mas_pkg::func_t'($urandom_range(0, 7)), pick_operand(m), pick_operand(m),
               pick_operand(m));
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid || cfg_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    fail_count = fail_count + expected_results.size();
    $display("%0d requests checked over %0d modulus writes, %0d not invertible",
             accepted_cnt, cfg_writes, domain_errs);
    $display("output held off for a long stretch %0d times", long_holds);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : limit_proc
    #30000000;
    $display("timeout waiting for results");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mas_pkg.sv
rtl/core/mas_div.sv
rtl/core/modular_alu_small_modulus.sv
sim/testbench.sv
